// File: rtl/core/variable_step_lowpass_filter_top_defines.svh
// Assertion helpers for the variable step low-pass filter.
`ifndef VARIABLE_STEP_LOWPASS_FILTER_TOP_DEFINES_SVH
`define VARIABLE_STEP_LOWPASS_FILTER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define VSLPF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define VSLPF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/vslpf_pkg.sv
package vslpf_pkg;

	localparam int MAX_CH     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TAU_W      = 32;
	localparam int ALPHA_W    = 17;
	localparam int FRAC_BITS  = 16;
	localparam int DIV_STEPS  = 17;
	localparam int STEP_W     = 5;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
	localparam logic [TAU_W-1:0]   TAU_RESET = 32'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TC0  = 3'd0,
		REG_TC1  = 3'd1,
		REG_TC2  = 3'd2,
		REG_TC3  = 3'd3,
		REG_MASK = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic div;
		logic div_first;
		logic mul;
		logic acc;
		logic emit;
	} vslpf_cmd_t;

endpackage

// File: rtl/core/vslpf_ctrl.sv
module vslpf_ctrl
	import vslpf_pkg::*;
#(
	parameter int NUM_CHANNELS = 4,
	parameter int CH_W         = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output vslpf_cmd_t      cmd,
	output logic [CH_W-1:0] ch
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [CH_W-1:0]   ch_q;
	logic              m_tvalid_q;
	logic              slot_free;

	assign slot_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && s_tvalid;
		cmd.setup     = (state_q == ST_SETUP);
		cmd.div       = (state_q == ST_DIV);
		cmd.div_first = (state_q == ST_DIV) && (step_q == '0);
		cmd.mul       = (state_q == ST_MUL);
		cmd.acc       = (state_q == ST_ACC);
		cmd.emit      = (state_q == ST_DONE) && slot_free;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign ch       = ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			ch_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && slot_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SETUP;
						ch_q    <= '0;
					end
				end
				ST_SETUP: begin
					state_q <= ST_DIV;
					step_q  <= '0;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1))
						state_q <= ST_MUL;
					else
						step_q <= step_q + STEP_W'(1);
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= ST_SETUP;
					end
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/vslpf_datapath.sv
module vslpf_datapath
	import vslpf_pkg::*;
#(
	parameter int NUM_CHANNELS = 4,
	parameter int SAMPLE_WIDTH = 32,
	parameter int TIME_WIDTH   = 48,
	parameter int CH_W         = 2,
	parameter int DATA_W       = 176
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vslpf_cmd_t            cmd,
	input  logic [CH_W-1:0]       ch,
	input  logic [DATA_W-1:0]     s_tdata,
	output logic [DATA_W-1:0]     m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int DW = ((TIME_WIDTH > TAU_W) ? TIME_WIDTH : TAU_W) + 1;
	localparam int PW = SAMPLE_WIDTH + ALPHA_W + 2;
	localparam int SW = SAMPLE_WIDTH;

	logic [TAU_W-1:0]        tau_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] en_q;

	logic [TIME_WIDTH-1:0] prev_time_q;
	logic [TIME_WIDTH-1:0] time_q;
	logic [TIME_WIDTH-1:0] dt_q;
	logic [SW-1:0]         x_q    [NUM_CHANNELS];
	logic [SW-1:0]         prev_q [NUM_CHANNELS];

	logic [DW-1:0]      s_q;
	logic [DW-1:0]      r_q;
	logic [ALPHA_W-1:0] q_q;
	logic               zero_q;
	logic signed [PW-1:0] prod_q;
	logic [DATA_W-1:0]  out_q;

	logic [TIME_WIDTH-1:0] now;
	logic [TAU_W-1:0]      tau_sel;
	logic [DW-1:0]         sum_w;
	logic [DW-1:0]         half_dt;
	logic [DW-1:0]         half_s;
	logic                  ovf;
	logic [DW:0]           r2;
	logic [DW:0]           sx;
	logic                  ge;
	logic [ALPHA_W-1:0]    alpha;
	logic [SW-1:0]         x_sel;
	logic [SW-1:0]         p_sel;
	logic signed [SW:0]    diff;
	logic signed [ALPHA_W:0] alpha_s;
	logic signed [PW-1:0]  prod_w;
	logic signed [PW-1:0]  acc_w;
	logic [SW-1:0]         sat_w;
	logic [SW-1:0]         new_val;
	logic [DATA_W-1:0]     out_w;

	assign now     = s_tdata[TIME_WIDTH-1:0];
	assign tau_sel = tau_q[ch];
	assign sum_w   = DW'(dt_q) + DW'(tau_sel);
	assign ovf     = (TIME_WIDTH == 64) && sum_w[DW-1];
	assign half_dt = DW'(dt_q >> 1);
	assign half_s  = half_dt + DW'(tau_sel >> 1) + DW'(1);

	assign r2 = {r_q, 1'b0};
	assign sx = {1'b0, s_q};
	assign ge = cmd.div_first ? (r_q >= s_q) : (r2 >= sx);

	assign alpha   = zero_q ? ALPHA_ONE : q_q;
	assign x_sel   = x_q[ch];
	assign p_sel   = prev_q[ch];
	assign diff    = $signed({x_sel[SW-1], x_sel}) - $signed({p_sel[SW-1], p_sel});
	assign alpha_s = $signed({1'b0, alpha});
	assign prod_w  = alpha_s * diff;

	// floor(alpha * d / 2^16) added to the old value, clamped to the sample range
	assign acc_w = (prod_q >>> FRAC_BITS) + PW'($signed(p_sel));

	always_comb begin
		if (acc_w[PW-1:SW-1] == '0 || acc_w[PW-1:SW-1] == '1)
			sat_w = acc_w[SW-1:0];
		else if (acc_w[PW-1])
			sat_w = {1'b1, {(SW-1){1'b0}}};
		else
			sat_w = {1'b0, {(SW-1){1'b1}}};
	end

	assign new_val = en_q[ch] ? sat_w : x_sel;

	always_comb begin
		out_w = '0;
		out_w[TIME_WIDTH-1:0] = time_q;
		for (int i = 0; i < NUM_CHANNELS; i++)
			out_w[TIME_WIDTH + i*SW +: SW] = prev_q[i];
	end

	assign m_tdata = out_q;

	for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_tau
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				tau_q[g] <= TAU_RESET;
			else if (cfg_we && cfg_index == CFG_IDX_W'(int'(REG_TC0) + g))
				tau_q[g] <= cfg_wdata[TAU_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			en_q <= '1;
		else if (cfg_we && cfg_index == REG_MASK)
			en_q <= cfg_wdata[NUM_CHANNELS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++)
				prev_q[i] <= '0;
		end else begin
			if (cmd.load)
				prev_time_q <= now;
			if (cmd.acc)
				prev_q[ch] <= new_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			time_q <= now;
			dt_q   <= (now >= prev_time_q) ? now - prev_time_q : '0;
			for (int i = 0; i < NUM_CHANNELS; i++)
				x_q[i] <= s_tdata[TIME_WIDTH + i*SW +: SW];
		end
		if (cmd.setup) begin
			s_q    <= ovf ? half_s : sum_w;
			r_q    <= ovf ? half_dt : DW'(dt_q);
			zero_q <= (sum_w == '0);
			q_q    <= '0;
		end
		if (cmd.div) begin
			if (cmd.div_first) begin
				q_q <= ALPHA_W'(ge);
				if (ge)
					r_q <= r_q - s_q;
			end else begin
				q_q <= {q_q[ALPHA_W-2:0], ge};
				r_q <= ge ? DW'(r2 - sx) : DW'(r2);
			end
		end
		if (cmd.mul)
			prod_q <= prod_w;
		if (cmd.emit)
			out_q <= out_w;
	end

endmodule

// File: rtl/core/variable_step_lowpass_filter_top.sv
// Variable time step first-order low-pass filter over a vector of samples.
// Input stream (s_*): one request carries a timestamp and one signed sample
// per channel. Output stream (m_*): one request per input, carrying the same
// timestamp and the filtered vector. Per channel, alpha = dt / (dt + tau)
// in Q1.16 and new = prev + floor(alpha * (x - prev) / 2^16).
// Config port: cfg_we writes cfg_wdata to register cfg_index:
// 0..3 channel time constants, 4 channel enable mask.
// Sequence: each channel passes through setup, 17 steps of the shared
// restoring divider, multiply and accumulate; m_tvalid rises after the
// last channel is done. One item is in work at a time;
// s_tready is high only while no item is in work.
// The output register holds a finished result while the receiver stalls,
// and the next item is accepted and computed meanwhile; it waits only for
// the output register to empty before it is loaded.
// Reset clears the stored filter values and the previous timestamp to zero,
// sets all time constants to 1000 and enables all channels.
`include "variable_step_lowpass_filter_top_defines.svh"

module variable_step_lowpass_filter_top
	import vslpf_pkg::*;
#(
	parameter int NUM_CHANNELS = 4,
	parameter int SAMPLE_WIDTH = 32,
	parameter int TIME_WIDTH   = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// sample_time, sample_0, sample_1, sample_2, sample_3, zero fill
	input  logic [((TIME_WIDTH + MAX_CH*SAMPLE_WIDTH + 7)/8)*8-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// filtered_time, filtered_0, filtered_1, filtered_2, filtered_3, zero fill
	output logic [((TIME_WIDTH + MAX_CH*SAMPLE_WIDTH + 7)/8)*8-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int DATA_W = ((TIME_WIDTH + MAX_CH*SAMPLE_WIDTH + 7)/8)*8;
	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	vslpf_cmd_t      cmd;
	logic [CH_W-1:0] ch;

	vslpf_ctrl #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.CH_W        (CH_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.ch      (ch)
	);

	vslpf_datapath #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH),
		.CH_W        (CH_W),
		.DATA_W      (DATA_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.ch       (ch),
		.s_tdata  (s_tdata),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	`VSLPF_ASSERT(a_busy_after_load, cmd.load |=> !s_tready, "accepted while busy")
	`VSLPF_ASSERT(a_emit_slot_free, cmd.emit |-> (!m_tvalid || m_tready), "result overwritten")
	`VSLPF_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.setup, cmd.div, cmd.mul, cmd.acc, cmd.emit}), "commands overlap")
	`VSLPF_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!m_tvalid && s_tready), "not idle in reset")

endmodule
